// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic check on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clk_sig, rstn_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
        else $error(msg);

// Check on the house clock and reset names.
`define ASSERT_STD(label, prop, msg) \
    `ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

// ===== hdl/ppi_pkg.sv =====
// Package with shared types and constants of the progress interleaver.
`timescale 1ns / 1ps

package ppi_pkg;

    localparam int GROUPS_DEF     = 8;
    localparam int COUNT_BITS_DEF = 16;
    localparam int SEQ_BITS       = 19;
    localparam int SEL_BITS       = 3;
    localparam int ITEM_BITS      = 16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_GRANT = 1'b1;

    typedef struct packed {
        logic                 op;
        logic [SEL_BITS-1:0]  group_sel;
        logic [ITEM_BITS-1:0] group_items;
    } cmd_t;

    typedef struct packed {
        logic [SEL_BITS-1:0] granted_group;
        logic                grant_valid;
        logic [SEQ_BITS-1:0] sequence_pos;
        logic                group_last;
        logic                all_done;
    } result_t;

endpackage

// ===== hdl/proportional_progress_interleaver.sv =====
// Top level of the proportional progress interleaver.
`timescale 1ns / 1ps
// Usage:
// A command is taken at a rising edge with start high and busy low. A load
// command sets one group's total and clears its fetched count; a grant
// command picks the unfinished group with the smallest fetched/total ratio
// (ties to the larger total, then the larger index) and counts one item.
// Every command returns exactly one result, shown on the result port for
// one cycle with done high; the receiver cannot hold it off.
// Scan: each command scans all groups through one shared cross-multiply
// comparator: a read state, then a product state and a compare state for
// each group, then a commit cycle. busy stays high from the accepting edge
// through the commit cycle; done is high in the first cycle with busy low,
// and a new command may be taken in that same cycle, so the block does not
// take a new command before it is through with the last one.
// The scan time is set by the single comparator and the one read port of
// the count store.
// Reset clears the sequence counter and the store's valid bits at once, so
// all totals and fetched counts read as zero; the block is ready right
// after reset is released.
module proportional_progress_interleaver #(
    parameter int GROUPS     = ppi_pkg::GROUPS_DEF,
    parameter int COUNT_BITS = ppi_pkg::COUNT_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  ppi_pkg::cmd_t   cmd,
    output logic            done,
    output ppi_pkg::result_t result
);
    import ppi_pkg::*;

    `include "assert_macros.svh"

    localparam int AW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CW = $clog2(GROUPS + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(GROUPS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_CMP  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic                  finish_reg, finish_next;
    logic                  op_reg;
    logic [AW-1:0]         idx_reg;
    logic                  best_valid_reg;
    logic [AW-1:0]         best_idx_reg;
    logic [COUNT_BITS-1:0] best_fetched_reg;
    logic [COUNT_BITS-1:0] best_total_reg;
    logic [CW-1:0]         unfinished_reg;
    logic [SEQ_BITS-1:0]   issued_reg;
    logic                  done_reg;
    result_t               result_reg;

    logic                  accept;
    logic                  load_hit;
    logic [31:0]           items_wide;
    logic [COUNT_BITS-1:0] load_total;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [COUNT_BITS-1:0] wr_total;
    logic [COUNT_BITS-1:0] wr_fetched;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [COUNT_BITS-1:0] rd_total;
    logic [COUNT_BITS-1:0] rd_fetched;
    logic                  ahead;
    logic                  cand_open;
    logic                  grant_hit;
    logic [COUNT_BITS-1:0] best_fetched_inc;
    logic                  last_hit;

    assign accept     = start && !busy;
    assign load_hit   = accept && (cmd.op == OP_LOAD) && (int'(cmd.group_sel) < GROUPS);
    assign items_wide = 32'(cmd.group_items);
    assign load_total = (items_wide > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(items_wide);

    assign grant_hit        = finish_reg && (op_reg == OP_GRANT) && best_valid_reg;
    assign best_fetched_inc = best_fetched_reg + 1'b1;
    assign last_hit         = (best_fetched_inc == best_total_reg);

    // Loads write at the accepting edge; grants write back in the commit cycle.
    always_comb
    begin
        if (grant_hit)
        begin
            wr_en      = 1'b1;
            wr_addr    = best_idx_reg;
            wr_total   = best_total_reg;
            wr_fetched = best_fetched_inc;
        end
        else
        begin
            wr_en      = load_hit;
            wr_addr    = AW'(cmd.group_sel);
            wr_total   = load_total;
            wr_fetched = '0;
        end
    end

    assign cand_open = (rd_fetched < rd_total);
    assign rd_en     = (state_reg == ST_READ) ||
                       ((state_reg == ST_CMP) && (idx_reg != LAST_IDX));
    assign rd_addr   = (state_reg == ST_CMP) ? AW'(idx_reg + 1'b1) : idx_reg;

    ppi_store #(
        .GROUPS     (GROUPS),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_total   (wr_total),
        .wr_fetched (wr_fetched),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_total   (rd_total),
        .rd_fetched (rd_fetched)
    );

    ppi_cmp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_cmp (
        .clk          (clk),
        .cand_fetched (rd_fetched),
        .cand_total   (rd_total),
        .best_fetched (best_fetched_reg),
        .best_total   (best_total_reg),
        .ahead        (ahead)
    );

    always_comb
    begin
        state_next  = state_reg;
        finish_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !finish_reg)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next  = ST_IDLE;
                    finish_next = 1'b1;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE) || finish_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            finish_reg     <= 1'b0;
            op_reg         <= OP_LOAD;
            idx_reg        <= '0;
            best_valid_reg <= 1'b0;
            unfinished_reg <= '0;
            issued_reg     <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            finish_reg <= finish_next;
            done_reg   <= finish_reg;
            if (accept)
            begin
                op_reg         <= cmd.op;
                idx_reg        <= '0;
                best_valid_reg <= 1'b0;
                unfinished_reg <= '0;
            end
            else if (state_reg == ST_CMP)
            begin
                if (cand_open)
                begin
                    unfinished_reg <= unfinished_reg + 1'b1;
                    if (!best_valid_reg || ahead)
                    begin
                        best_valid_reg <= 1'b1;
                    end
                end
                if (idx_reg != LAST_IDX)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (grant_hit)
            begin
                issued_reg <= issued_reg + 1'b1;
            end
        end
    end

    // Best candidate payload follows the valid flag above.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_CMP) && cand_open && (!best_valid_reg || ahead))
        begin
            best_idx_reg     <= idx_reg;
            best_fetched_reg <= rd_fetched;
            best_total_reg   <= rd_total;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish_reg)
        begin
            result_reg.granted_group <= grant_hit ? SEL_BITS'(best_idx_reg) : '0;
            result_reg.grant_valid   <= grant_hit;
            result_reg.sequence_pos  <= grant_hit ? issued_reg : '0;
            result_reg.group_last    <= grant_hit && last_hit;
            if (grant_hit)
            begin
                result_reg.all_done <= (unfinished_reg == CW'(1)) && last_hit;
            end
            else
            begin
                result_reg.all_done <= (unfinished_reg == '0);
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_STD(a_done_single, done |=> !done, "result strobe lasted more than one cycle")
    `ASSERT_STD(a_accept_busy, start && !busy |=> busy, "accepted transaction did not raise busy")
    `ASSERT_STD(a_done_after_finish, done |-> $past(finish_reg), "result without a commit cycle")
    `ASSERT_STD(a_no_grant_done, done && !result.grant_valid && result.group_last |-> 1'b0,
                "group_last set on a transaction without a grant")
    `ASSERT_STD(a_best_in_range, grant_hit |-> (int'(best_idx_reg) < GROUPS),
                "granted group index out of range")

endmodule

// ===== hdl/ppi_store.sv =====
// Per-group total and fetched counts with a registered read port.
`timescale 1ns / 1ps

module ppi_store #(
    parameter int GROUPS     = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [$clog2(GROUPS)-1:0]     wr_addr,
    input  logic [COUNT_BITS-1:0]         wr_total,
    input  logic [COUNT_BITS-1:0]         wr_fetched,
    input  logic                          rd_en,
    input  logic [$clog2(GROUPS)-1:0]     rd_addr,
    output logic [COUNT_BITS-1:0]         rd_total,
    output logic [COUNT_BITS-1:0]         rd_fetched
);
    import ppi_pkg::*;

    logic [COUNT_BITS-1:0] total_mem   [GROUPS];
    logic [COUNT_BITS-1:0] fetched_mem [GROUPS];
    logic [GROUPS-1:0]     valid_reg;
    logic [COUNT_BITS-1:0] rd_total_reg;
    logic [COUNT_BITS-1:0] rd_fetched_reg;

    // Entries not written since reset read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            total_mem[wr_addr]   <= wr_total;
            fetched_mem[wr_addr] <= wr_fetched;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_total_reg   <= valid_reg[rd_addr] ? total_mem[rd_addr] : '0;
            rd_fetched_reg <= valid_reg[rd_addr] ? fetched_mem[rd_addr] : '0;
        end
    end

    assign rd_total   = rd_total_reg;
    assign rd_fetched = rd_fetched_reg;

endmodule

// ===== hdl/ppi_cmp.sv =====
// Cross-multiply fraction comparator shared by every step of the scan.
`timescale 1ns / 1ps

module ppi_cmp #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  clk,
    input  logic [COUNT_BITS-1:0] cand_fetched,
    input  logic [COUNT_BITS-1:0] cand_total,
    input  logic [COUNT_BITS-1:0] best_fetched,
    input  logic [COUNT_BITS-1:0] best_total,
    output logic                  ahead
);
    import ppi_pkg::*;

    logic [2*COUNT_BITS-1:0] lhs_reg;
    logic [2*COUNT_BITS-1:0] rhs_reg;
    logic                    total_ge_reg;

    // Products are registered; the compare happens in the following cycle.
    always_ff @(posedge clk)
    begin
        lhs_reg      <= (2*COUNT_BITS)'(cand_fetched) * (2*COUNT_BITS)'(best_total);
        rhs_reg      <= (2*COUNT_BITS)'(best_fetched) * (2*COUNT_BITS)'(cand_total);
        total_ge_reg <= (cand_total >= best_total);
    end

    // The scan runs in ascending index order, so on equal fractions and
    // equal totals the candidate always has the larger index and wins.
    assign ahead = (lhs_reg < rhs_reg) || ((lhs_reg == rhs_reg) && total_ge_reg);

endmodule
